// File: rtl/lmpc_pkg.sv
// Shared types and constants of the modulated phase cycler.
package lmpc_pkg;

   // Default depth of the quarter-wave sine table
   localparam int SINE_DEPTH_DEFAULT = 256;

   // Register limits
   localparam int LIM_RATE   = 40960;
   localparam int LIM_OFFSET = 4096;

   // Register indexes
   typedef enum logic [2:0] {
      REG_WAVE_MODE = 3'd0,
      REG_MOD_RATE  = 3'd1,
      REG_MOD_AMP   = 3'd2,
      REG_TIME_OFFS = 3'd3,
      REG_BASE_FREQ = 3'd4
   } reg_index_type;

   // Oscillator modes
   typedef enum logic [2:0] {
      MODE_NONE   = 3'd0,
      MODE_SINE   = 3'd1,
      MODE_SQUARE = 3'd2,
      MODE_TRI    = 3'd3,
      MODE_SAW    = 3'd4,
      MODE_WALK   = 3'd5
   } wave_mode_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PHASE,
      ST_SHAPE,
      ST_AMP,
      ST_MOD,
      ST_INC,
      ST_DONE
   } seq_state_type;

endpackage

// File: rtl/lfo_modulated_phase_cycler.sv
// Top level of the modulated phase cycler: oscillator, walk and phase accumulator.
//
// Each item (time, frame time, random bit) yields one result (modulation, phase).
// One 17 x 33 bit multiplier is shared by all products; a small sequencer runs
// it for the oscillator phase, the amplitude or walk-step product and the phase
// increment. After acceptance it steps through the phase, shape, amplitude,
// modulation, increment and done states to the output register and returns to
// idle before it accepts again, so the block takes no new item while one is in
// flight; the done step waits while the previous result is still unread.
// req_tready is high only while the sequencer is idle.
// The output register lets the next item enter while a result is pending.
// The sine table has SINE_TABLE_DEPTH+1 constant entries; no clearing pass.
module lfo_modulated_phase_cycler #(
   parameter int SINE_TABLE_DEPTH = lmpc_pkg::SINE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [16:0] csr_wdata,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // now_time[31:0], tick_length[47:32]
   input  logic        req_tuser,   // coin_bit
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // modulation[16:0], phase_out[32:17], zero
);
   import lmpc_pkg::*;

   localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   // Quarter-wave sine entry, Q1.12, from an integer Taylor series
   function automatic logic [12:0] sine_rom(input int i);
      longint unsigned x, x2, term, r;
      longint sum;
      x = (PI_HALF_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      sum = longint'(x);
      term = x;
      term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
      if (sum < 0) sum = 0;
      r = (longint'(sum) * 4096 + (64'd1 << 29)) >> 30;
      if (r > 4096) r = 4096;
      return r[12:0];
   endfunction

   logic [12:0] sine_tab [SINE_TABLE_DEPTH+1];
   for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
      assign sine_tab[g] = sine_rom(g);
   end

   // Registers
   seq_state_type      state_ff, state_in;
   logic [2:0]         mode_ff, mode_in;
   logic signed [16:0] rate_ff, rate_in;
   logic [15:0]        amp_ff, amp_in;
   logic signed [13:0] offs_ff, offs_in;
   logic signed [16:0] base_ff, base_in;
   logic [31:0]        now_ff, now_in;
   logic [15:0]        tick_ff, tick_in;
   logic               coin_ff, coin_in;
   logic [49:0]        prod_ff, prod_in;
   logic               pneg_ff, pneg_in;
   logic [12:0]        vmag_ff, vmag_in;
   logic               vneg_ff, vneg_in;
   logic signed [16:0] walk_ff, walk_in;
   logic               ineg_ff, ineg_in;
   logic [15:0]        phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [39:0]        rsp_data_ff, rsp_data_in;

   // Combinational helpers
   logic               in_acc, out_free;
   logic signed [33:0] t_s;
   logic [33:0]        t_abs;
   logic [16:0]        rate_mag;
   logic [16:0]        mul_a;
   logic [32:0]        mul_b;
   logic [49:0]        p_tc;
   logic [15:0]        fr;
   logic [IW+13:0]     idx_full;
   logic [IW-1:0]      idx, idx_sel;
   logic signed [18:0] step_s, mod_raw, amp_s;
   logic signed [17:0] sum_s;
   logic [17:0]        sum_abs;
   logic [16:0]        csr_s17;
   logic signed [16:0] csr_r17;
   logic signed [13:0] csr_r14;

   assign in_acc   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_PHASE;
         ST_PHASE: state_in = ST_SHAPE;
         ST_SHAPE: state_in = ST_AMP;
         ST_AMP:   state_in = ST_MOD;
         ST_MOD:   state_in = ST_INC;
         ST_INC:   state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: ready and multiplier operands
   always_comb begin
      req_tready = 1'b0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_PHASE: begin
            mul_a = rate_mag;
            mul_b = t_abs[32:0];
         end
         ST_AMP: begin
            if (mode_ff == MODE_WALK) begin
               mul_a = rate_mag;
               mul_b = {17'd0, tick_ff};
            end else begin
               mul_a = {4'd0, vmag_ff};
               mul_b = {17'd0, amp_ff};
            end
         end
         ST_INC: begin
            mul_a = sum_abs[16:0];
            mul_b = {17'd0, tick_ff};
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Oscillator time and magnitudes; hold the increment product while the result waits
   always_comb begin
      t_s      = $signed({2'b00, now_ff}) + ($signed({{20{offs_ff[13]}}, offs_ff}) <<< 4);
      t_abs    = t_s[33] ? 34'(-t_s) : 34'(t_s);
      rate_mag = rate_ff[16] ? 17'(-rate_ff) : 17'(rate_ff);
      prod_in  = (state_ff == ST_DONE) ? prod_ff : 50'(mul_a) * 50'(mul_b);
      pneg_in  = pneg_ff;
      if (state_ff == ST_PHASE) pneg_in = rate_ff[16] ^ t_s[33];
   end

   // Wave shape: magnitude and sign of the unit waveform
   always_comb begin
      p_tc     = pneg_ff ? 50'(-prod_ff) : prod_ff;
      fr       = p_tc[27:12];
      idx_full = ({{IW{1'b0}}, fr[13:0]} * (IW+14)'(SINE_TABLE_DEPTH)) >> 14;
      idx      = idx_full[IW-1:0];
      idx_sel  = fr[14] ? IW'(SINE_TABLE_DEPTH) - idx : idx;
      vmag_in  = vmag_ff;
      vneg_in  = vneg_ff;
      if (state_ff == ST_SHAPE) begin
         case (mode_ff)
            MODE_SINE: begin
               vmag_in = sine_tab[idx_sel];
               vneg_in = fr[15];
            end
            MODE_SQUARE: begin
               vmag_in = 13'd4096;
               vneg_in = prod_ff[27];
            end
            MODE_TRI: begin
               vmag_in = prod_ff[26] ? 13'd4096 - {1'b0, prod_ff[25:14]}
                                     : {1'b0, prod_ff[25:14]};
               vneg_in = prod_ff[27];
            end
            MODE_SAW: begin
               vmag_in = prod_ff[27] ? 13'd4096 - {1'b0, prod_ff[26:15]}
                                     : {1'b0, prod_ff[26:15]};
               vneg_in = prod_ff[27];
            end
            default: begin
               vmag_in = '0;
               vneg_in = 1'b0;
            end
         endcase
      end
   end

   // Modulation value, clamped to the amplitude
   always_comb begin
      amp_s   = $signed({3'b000, amp_ff});
      step_s  = rate_ff[16] ? -$signed({2'b00, prod_ff[32:16]})
                            : $signed({2'b00, prod_ff[32:16]});
      if (mode_ff == MODE_WALK) begin
         mod_raw = coin_ff ? 19'(walk_ff) - step_s : 19'(walk_ff) + step_s;
      end else begin
         mod_raw = vneg_ff ? -$signed({2'b00, prod_ff[28:12]})
                           : $signed({2'b00, prod_ff[28:12]});
      end
      walk_in = walk_ff;
      if (state_ff == ST_MOD) begin
         if (mod_raw > amp_s)       walk_in = amp_s[16:0];
         else if (mod_raw < -amp_s) walk_in = 17'(-amp_s);
         else                       walk_in = mod_raw[16:0];
      end
   end

   // Increment sign and phase accumulator
   always_comb begin
      sum_s   = 18'(base_ff) + 18'(walk_ff);
      sum_abs = sum_s[17] ? 18'(-sum_s) : 18'(sum_s);
      ineg_in = ineg_ff;
      if (state_ff == ST_INC) ineg_in = sum_s[17];
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_DONE && out_free) begin
         phase_in     = ineg_ff ? phase_ff - prod_ff[27:12] : phase_ff + prod_ff[27:12];
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, phase_in, walk_ff};
      end
   end

   // Capture input item
   always_comb begin
      now_in  = in_acc ? req_tdata[31:0]  : now_ff;
      tick_in = in_acc ? req_tdata[47:32] : tick_ff;
      coin_in = in_acc ? req_tuser        : coin_ff;
   end

   // Configuration writes with saturation
   always_comb begin
      mode_in = mode_ff;
      rate_in = rate_ff;
      amp_in  = amp_ff;
      offs_in = offs_ff;
      base_in = base_ff;
      csr_s17 = csr_wdata;
      csr_r17 = $signed(csr_s17);
      csr_r14 = $signed(csr_wdata[13:0]);
      if (csr_r17 > 17'sd40960)       csr_r17 = 17'sd40960;
      else if (csr_r17 < -17'sd40960) csr_r17 = -17'sd40960;
      if (csr_r14 > 14'sd4096)        csr_r14 = 14'sd4096;
      else if (csr_r14 < -14'sd4096)  csr_r14 = -14'sd4096;
      if (csr_we) begin
         case (csr_addr)
            REG_WAVE_MODE: if (csr_wdata[2:0] <= MODE_WALK) mode_in = csr_wdata[2:0];
            REG_MOD_RATE:  rate_in = csr_r17;
            REG_MOD_AMP:   amp_in = (csr_wdata[15:0] > 16'(LIM_RATE)) ? 16'(LIM_RATE)
                                                                      : csr_wdata[15:0];
            REG_TIME_OFFS: offs_in = csr_r14;
            REG_BASE_FREQ: base_in = csr_r17;
            default:       mode_in = mode_ff;
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= '0;
         rate_ff      <= '0;
         amp_ff       <= '0;
         offs_ff      <= '0;
         base_ff      <= '0;
         walk_ff      <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rate_ff      <= rate_in;
         amp_ff       <= amp_in;
         offs_ff      <= offs_in;
         base_ff      <= base_in;
         walk_ff      <= walk_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      tick_ff     <= tick_in;
      coin_ff     <= coin_in;
      prod_ff     <= prod_in;
      pneg_ff     <= pneg_in;
      vmag_ff     <= vmag_in;
      vneg_ff     <= vneg_in;
      ineg_ff     <= ineg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_start: assert property (@(posedge clock) disable iff (reset)
      in_acc |=> state_ff == ST_PHASE)
      else $error("accepted item did not start the sequencer");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INC |-> (walk_ff <= $signed({1'b0, amp_ff}))
                          && (walk_ff >= -$signed({1'b0, amp_ff})))
      else $error("modulation outside amplitude");
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DONE) |=> $stable(phase_ff))
      else $error("phase changed outside the update step");
`endif

endmodule

// File: sim/tb_lfo_modulated_phase_cycler.sv
// Self-checking testbench of the modulated phase cycler: random and directed ticks.
`timescale 1ns / 100ps

module tb_lfo_modulated_phase_cycler;
   import lmpc_pkg::*;

   localparam int DEPTH = 256;

   typedef struct packed {
      logic [31:0] now_time;
      logic [15:0] tick_length;
      logic        coin_bit;
   } tick_item_type;

   typedef struct packed {
      logic signed [16:0] modulation;
      logic [15:0]        phase_out;
   } cycle_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [16:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   lfo_modulated_phase_cycler #(.SINE_TABLE_DEPTH(DEPTH)) uut (.*);

   always #5 clock = ~clock;

   // predictor copy of registers and state
   int unsigned   cur_mode;
   longint        cur_rate, cur_amp, cur_offset, cur_base;
   longint        walk_level;
   longint        phase_acc;
   longint        quarter_sine [0:DEPTH];

   tick_item_type    pending_ticks[$];
   cycle_result_type expected_results[$];
   int               errors = 0;
   int               results_seen = 0;
   bit               calm = 0;
   bit               hold_send = 0;
   tick_item_type    front_tick;
   logic             req_tready_q = 1'b0;

   // build the quarter-wave table with the same integer series
   function automatic longint sine_entry(longint i);
      longint unsigned x, x2, term, r;
      longint sum;
      x = (64'd1686629713 * i) / DEPTH;
      x2 = (x * x) >> 30;
      sum = x;
      term = x;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
         if (k & 1) sum -= term;
         else sum += term;
      end
      if (sum < 0) sum = 0;
      r = (sum * 4096 + (64'd1 << 29)) >> 30;
      if (r > 4096) r = 4096;
      return r;
   endfunction

   function automatic longint mag_of(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint amp_scale(longint v, longint a);
      longint m;
      m = (mag_of(v) * a) >> 12;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint clip(longint v, longint lim);
      return v < -lim ? -lim : (v > lim ? lim : v);
   endfunction

   // apply a register write to the predictor
   task automatic shadow_write(logic [2:0] idx, logic [16:0] val);
      case (idx)
         REG_WAVE_MODE: if (val[2:0] <= MODE_WALK) cur_mode = val[2:0];
         REG_MOD_RATE:  cur_rate = clip(longint'($signed(val)), LIM_RATE);
         REG_MOD_AMP:   cur_amp = (val[15:0] > LIM_RATE) ? LIM_RATE : val[15:0];
         REG_TIME_OFFS: cur_offset = clip(longint'($signed(val[13:0])), LIM_OFFSET);
         REG_BASE_FREQ: cur_base = clip(longint'($signed(val)), LIM_RATE);
         default: ;
      endcase
   endtask

   // compute the result of one tick and advance the state
   task automatic predict_cycle(tick_item_type it);
      longint t, p, modv, c, f, prod, inc, stp, s;
      longint unsigned fr, idx;
      cycle_result_type r;
      t = longint'(it.now_time) + cur_offset * 16;
      p = cur_rate * t;
      modv = 0;
      case (cur_mode)
         MODE_SINE: begin
            fr = (p >> 12) & 16'hFFFF;
            idx = ((fr & 16'h3FFF) * DEPTH) >> 14;
            s = fr[14] ? quarter_sine[DEPTH - idx] : quarter_sine[idx];
            if (fr[15]) s = -s;
            modv = amp_scale(s, cur_amp);
         end
         MODE_SQUARE: begin
            c = mag_of(p) * 2;
            modv = ((c >> 28) & 1) ? -cur_amp : cur_amp;
         end
         MODE_TRI: begin
            c = mag_of(p) * 4;
            f = (c & ((64'd1 << 28) - 1)) >> 16;
            case ((c >> 28) & 3)
               0: modv = amp_scale(f, cur_amp);
               1: modv = amp_scale(4096 - f, cur_amp);
               2: modv = amp_scale(-f, cur_amp);
               default: modv = amp_scale(f - 4096, cur_amp);
            endcase
         end
         MODE_SAW: begin
            c = mag_of(p) * 2;
            f = (c & ((64'd1 << 28) - 1)) >> 16;
            modv = ((c >> 28) & 1) ? amp_scale(f - 4096, cur_amp) : amp_scale(f, cur_amp);
         end
         MODE_WALK: begin
            stp = (mag_of(cur_rate) * it.tick_length) >> 16;
            if (cur_rate < 0) stp = -stp;
            modv = it.coin_bit ? walk_level - stp : walk_level + stp;
         end
         default: modv = 0;
      endcase
      modv = clip(modv, cur_amp);
      walk_level = modv;
      prod = (cur_base + modv) * longint'(it.tick_length);
      inc = (mag_of(prod) >> 12) & 16'hFFFF;
      phase_acc = (prod < 0 ? phase_acc - inc : phase_acc + inc) & 16'hFFFF;
      r.modulation = modv[16:0];
      r.phase_out = phase_acc[15:0];
      expected_results.push_back(r);
   endtask

   // drive items at the falling edge; predict at acceptance
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready_q) begin
            predict_cycle(front_tick);
            void'(pending_ticks.pop_front());
         end
         if (req_tvalid && !req_tready_q) begin
            // hold the waiting item until it is taken
            req_tvalid <= 1'b1;
         end else if (pending_ticks.size() > 0 && !hold_send &&
             (calm || $urandom_range(99) >= 11)) begin
            front_tick = pending_ticks[0];
            req_tdata <= {front_tick.tick_length, front_tick.now_time};
            req_tuser <= front_tick.coin_bit;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= calm || $urandom_range(99) >= 11;
      end
   end

   always @(posedge clock) req_tready_q <= req_tready & req_tvalid;

   // check results at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         cycle_result_type got, exp_r;
         got = {rsp_tdata[16:0], rsp_tdata[32:17]};
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("unexpected result item %h", rsp_tdata);
            errors++;
         end else begin
            exp_r = expected_results.pop_front();
            if (got.modulation !== exp_r.modulation) begin
               $error("modulation: expected %0d, actual %0d",
                      exp_r.modulation, got.modulation);
               errors++;
            end
            if (got.phase_out !== exp_r.phase_out) begin
               $error("phase_out: expected %0d, actual %0d",
                      exp_r.phase_out, got.phase_out);
               errors++;
            end
         end
      end
   end

   // write one register while idle
   task automatic csr_write(reg_index_type idx, logic [16:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      shadow_write(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   function automatic tick_item_type random_tick();
      tick_item_type it;
      it.now_time = $urandom();
      it.tick_length = ($urandom_range(3) == 0) ? 16'($urandom())
                                                : 16'($urandom_range(2000));
      it.coin_bit = 1'($urandom_range(1));
      return it;
   endfunction

   task automatic queue_tick(logic [31:0] nt, logic [15:0] tl, logic cb);
      tick_item_type it;
      it.now_time = nt;
      it.tick_length = tl;
      it.coin_bit = cb;
      pending_ticks.push_back(it);
   endtask

   initial begin
      logic [16:0] v;
      cur_mode = 0; cur_rate = 0; cur_amp = 0; cur_offset = 0; cur_base = 0;
      walk_level = 0; phase_acc = 0;
      for (int i = 0; i <= DEPTH; i++) quarter_sine[i] = sine_entry(i);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset registers, then each mode at extremes
      queue_tick(32'h0, 16'h0, 1'b0);
      queue_tick(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      wait_drained();
      csr_write(REG_MOD_RATE, 17'(LIM_RATE));
      csr_write(REG_MOD_AMP, 17'(LIM_RATE));
      csr_write(REG_TIME_OFFS, 17'(-LIM_OFFSET));
      csr_write(REG_BASE_FREQ, 17'(-LIM_RATE));
      for (int m = MODE_NONE; m <= MODE_WALK; m++) begin
         csr_write(REG_WAVE_MODE, 17'(m));
         queue_tick(32'h0, 16'hFFFF, 1'b0);
         queue_tick(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
         queue_tick(32'h0001_8000, 16'h0, 1'b0);
         // once, pause the sender until every expected result has come
         if (m == MODE_SQUARE) begin
            while (expected_results.size() == 0) @(negedge clock);
            hold_send = 1;
            while (req_tvalid || expected_results.size() > 0) @(negedge clock);
            hold_send = 0;
         end
         wait_drained();
      end
      // out of range writes, unused mode, index beyond the list
      csr_write(REG_WAVE_MODE, 17'd7);
      csr_write(REG_MOD_RATE, 17'h0FFFF);
      csr_write(REG_MOD_AMP, 17'h1FFFF);
      csr_write(REG_TIME_OFFS, 17'h01FFF);
      csr_write(REG_BASE_FREQ, 17'h10000);
      csr_write(reg_index_type'(3'd6), 17'h1FFFF);
      queue_tick(32'h8000_0000, 16'h8000, 1'b1);
      queue_tick(32'h0000_1234, 16'h0001, 1'b0);
      wait_drained();

      // random phases of about a hundred items each
      for (int ph = 0; ph < 18; ph++) begin
         calm = (ph == 9);
         csr_write(REG_WAVE_MODE, 17'($urandom_range(7)));
         v = (ph % 3 == 0) ? 17'($urandom_range(1) ? LIM_RATE : -LIM_RATE)
                           : 17'($urandom());
         csr_write(REG_MOD_RATE, v);
         csr_write(REG_MOD_AMP, (ph % 4 == 0) ? 17'(LIM_RATE) : 17'($urandom()));
         csr_write(REG_TIME_OFFS, 17'($urandom()));
         csr_write(REG_BASE_FREQ, (ph % 5 == 0) ? 17'(-LIM_RATE) : 17'($urandom()));
         for (int n = 0; n < 100; n++) pending_ticks.push_back(random_tick());
         wait_drained();
      end
      calm = 0;

      $display("covered all six wave modes, register clamping at both limits,");
      $display("%0d results checked with random idling on both sides", results_seen);
      if (errors == 0 && expected_results.size() == 0)
         $display("lfo_modulated_phase_cycler regression: pass");
      else
         $display("lfo_modulated_phase_cycler regression: fail");
      $finish;
   end

   // overall time limit
   initial begin
      #5ms;
      $display("lfo_modulated_phase_cycler regression: fail");
      $finish;
   end

endmodule

// File: lfo_modulated_phase_cycler.f
rtl/lmpc_pkg.sv
rtl/lfo_modulated_phase_cycler.sv
sim/tb_lfo_modulated_phase_cycler.sv
